/* rtl/bpa_pkg.sv */
package bpa_pkg;

   localparam int MAX_ORDER_DEF = 15;

   localparam int FUNC_W   = 2;
   localparam int ORDER_W  = 4;
   localparam int PAGE_W   = 15;
   localparam int STATUS_W = 2;
   localparam int RSV_W    = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_INIT  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_BLOCK = 2'd1,
      STATUS_BAD      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_BOOT,
      OP_ALLOC,
      OP_FREE,
      OP_INIT
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEVEL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SPLIT,
      ST_SET_RD,
      ST_SET_WR,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FILL,
      ST_RESP
   } st_type;

endpackage

/* rtl/bpa_if.sv */
interface bpa_req_if
   import bpa_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [ORDER_W-1:0] order;
   logic [PAGE_W-1:0]  page_index;

   modport source (output valid, func, order, page_index, input ready);
   modport sink   (input valid, func, order, page_index, output ready);
endinterface

interface bpa_rsp_if
   import bpa_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   result_page;

   modport source (output valid, status, result_page, input ready);
   modport sink   (input valid, status, result_page, output ready);
endinterface

/* rtl/buddy_page_allocator.sv */
// Buddy page allocator over a pool of 2^MAX_ORDER pages.
// req_if carries one command per transfer: allocate (func 0) a block of
// 2^order pages, free (func 1) the block at page_index, or initialize (func 2)
// the pool, freeing every page at or above the csr_wr_data value last written
// with csr_wr_en. Every command returns exactly one transfer on rsp_if with a
// status and, for a successful allocate, the first page of the block.
// One command is worked at a time; req_if.ready is high only while idle, so the
// next command is taken only after the previous result is loaded.
// The free bitmaps of all orders live in one single-port-read memory of
// 64-bit words, 2^(MAX_ORDER+1-6) words (1024 at the default order 15).
// Allocate scans the free bitmap word by word from the requested order upward
// and splits the first free block it finds down to the requested order; free
// merges with each free buddy order by order; init clears the memory and then
// writes the largest aligned free blocks from the reserved boundary up.
// A bad order, a misaligned free or an unknown func responds with STATUS_BAD.
// After reset the block sweeps the memory to zero with ready low; the register
// may be written meanwhile. A stalled rsp_if holds the finished result in the
// output register and the block waits before it reports the next result; a new
// command is taken while a result is waiting.
module buddy_page_allocator
   import bpa_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   bpa_req_if.sink          req_if,
   bpa_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [RSV_W-1:0] csr_wr_data
);

   // bit address space: order k starts at 2^(P+1) - 2^(P+1-k)
   localparam int BAW   = MAX_ORDER + 1;
   localparam int WL    = (MAX_ORDER < 6) ? MAX_ORDER : 6;
   localparam int W     = 1 << WL;
   localparam int AW    = BAW - WL;
   localparam int DEPTH = 1 << AW;
   localparam int LW    = $clog2(MAX_ORDER + 1);
   localparam int PGW   = MAX_ORDER;
   localparam int CW    = ((MAX_ORDER > PAGE_W) ? MAX_ORDER : PAGE_W) + 1;
   localparam int PPW   = ((BAW > RSV_W) ? BAW : RSV_W) + 1;

   localparam logic [BAW:0]    TOT    = {1'b1, {BAW{1'b0}}};
   localparam logic [PPW-1:0]  POOL_P = PPW'(1) << MAX_ORDER;
   localparam logic [CW-1:0]   POOL_C = CW'(1) << MAX_ORDER;
   localparam logic [LW-1:0]   TOP_LVL = LW'(MAX_ORDER);

   function automatic logic [WL-1:0] lowest_set(input logic [W-1:0] v);
      logic [WL-1:0] idx;
      idx = '0;
      for (int i = W - 1; i >= 0; i--) begin
         if (v[i]) idx = WL'(i);
      end
      return idx;
   endfunction

   st_type            state_ff, state_in;
   op_type            op_ff, op_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [LW-1:0]     order_ff, order_in;
   logic [PGW-1:0]    blk_ff, blk_in;
   logic [AW-1:0]     scan_w_ff, scan_w_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [PPW-1:0]    fill_ff, fill_in;
   status_type        status_ff, status_in;
   logic [PAGE_W-1:0] result_ff, result_in;
   logic [RSV_W-1:0]  reserved_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0] rsp_page_ff, rsp_page_in;

   // bitmap memory
   logic [W-1:0]      mem_ff [DEPTH];
   logic [W-1:0]      rd_data_ff;
   logic [AW-1:0]     mem_raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [W-1:0]      mem_wdata;

   // shared bit addressing
   logic [PGW-1:0]    blk_sel;
   logic [BAW:0]      off_full;
   logic [BAW:0]      hi_full;
   logic [LW:0]       lvl_p1;
   logic [BAW-1:0]    bit_addr;
   logic [AW-1:0]     word_addr;
   logic [WL-1:0]     bit_idx;
   logic [W-1:0]      bit_mask;

   // scan
   logic [AW-1:0]     lo_w, hi_w;
   logic [W-1:0]      lo_mask, hi_mask, scan_bits;
   logic              scan_hit;
   logic [WL-1:0]     scan_j;
   logic [BAW-1:0]    found_full;

   // request decode
   logic [CW-1:0]     page_w;
   logic [CW-1:0]     align_mask;
   logic              order_bad;
   logic [CW-1:0]     res_full;

   // init block size
   logic [LW-1:0]     fill_k;
   logic [PPW-1:0]    fill_shift;

   always_comb begin
      priority if (state_ff == ST_FREE_RD || state_ff == ST_FREE_CHK) begin
         blk_sel = blk_ff ^ PGW'(1);
      end else if ((state_ff == ST_SET_RD || state_ff == ST_SET_WR) && op_ff == OP_ALLOC) begin
         blk_sel = blk_ff | PGW'(1);
      end else begin
         blk_sel = blk_ff;
      end
   end

   assign off_full  = TOT - (TOT >> lvl_ff);
   assign lvl_p1    = (LW+1)'(lvl_ff) + (LW+1)'(1);
   assign hi_full   = TOT - (TOT >> lvl_p1) - (BAW+1)'(1);
   assign bit_addr  = off_full[BAW-1:0] + BAW'(blk_sel);
   assign word_addr = bit_addr[BAW-1:WL];
   assign bit_idx   = bit_addr[WL-1:0];
   assign bit_mask  = W'(1) << bit_idx;

   // mask off bits of the word that belong to neighboring orders
   assign lo_w      = off_full[BAW-1:WL];
   assign hi_w      = hi_full[BAW-1:WL];
   assign lo_mask   = (scan_w_ff == lo_w) ? ({W{1'b1}} << off_full[WL-1:0]) : {W{1'b1}};
   assign hi_mask   = (scan_w_ff == hi_w) ?
                      ({W{1'b1}} >> (WL'(W - 1) - hi_full[WL-1:0])) : {W{1'b1}};
   assign scan_bits = rd_data_ff & lo_mask & hi_mask;
   assign scan_hit  = |scan_bits;
   assign scan_j    = lowest_set(scan_bits);
   assign found_full = {scan_w_ff, scan_j} - off_full[BAW-1:0];

   assign page_w     = CW'(req_if.page_index);
   assign align_mask = (CW'(1) << req_if.order) - CW'(1);
   assign order_bad  = int'(req_if.order) > MAX_ORDER;
   assign res_full   = CW'(blk_ff) << order_ff;

   // largest aligned block at the fill pointer that stays inside the pool
   always_comb begin
      fill_k = '0;
      for (int i = 1; i <= MAX_ORDER; i++) begin
         if (((fill_ff & ((PPW'(1) << i) - PPW'(1))) == '0) &&
             ((fill_ff + (PPW'(1) << i)) <= POOL_P)) begin
            fill_k = LW'(i);
         end
      end
   end
   assign fill_shift = fill_ff >> fill_k;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lvl_in        = lvl_ff;
      order_in      = order_ff;
      blk_in        = blk_ff;
      scan_w_in     = scan_w_ff;
      clr_in        = clr_ff;
      fill_in       = fill_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      mem_raddr     = word_addr;
      mem_we        = 1'b0;
      mem_waddr     = word_addr;
      mem_wdata     = rd_data_ff | bit_mask;
      req_if.ready  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the bitmap memory to zero
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = (op_ff == OP_INIT) ? ST_FILL : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            status_in    = STATUS_DONE;
            result_in    = '0;
            if (req_if.valid) begin
               unique case (req_if.func)
                  FUNC_ALLOC: begin
                     if (order_bad) begin
                        status_in = STATUS_BAD;
                        state_in  = ST_RESP;
                     end else begin
                        op_in    = OP_ALLOC;
                        lvl_in   = LW'(req_if.order);
                        order_in = LW'(req_if.order);
                        state_in = ST_LEVEL;
                     end
                  end
                  FUNC_FREE: begin
                     if (order_bad || page_w >= POOL_C || (page_w & align_mask) != '0) begin
                        status_in = STATUS_BAD;
                        state_in  = ST_RESP;
                     end else begin
                        op_in    = OP_FREE;
                        lvl_in   = LW'(req_if.order);
                        blk_in   = PGW'(page_w >> req_if.order);
                        state_in = ST_FREE_RD;
                     end
                  end
                  FUNC_INIT: begin
                     op_in    = OP_INIT;
                     clr_in   = '0;
                     fill_in  = PPW'(reserved_ff);
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     status_in = STATUS_BAD;
                     state_in  = ST_RESP;
                  end
               endcase
            end
         end
         ST_LEVEL: begin
            scan_w_in = lo_w;
            state_in  = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            mem_raddr = scan_w_ff;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (scan_hit) begin
               // take the lowest free block and drop its bit
               mem_we    = 1'b1;
               mem_waddr = scan_w_ff;
               mem_wdata = rd_data_ff & ~(W'(1) << scan_j);
               blk_in    = found_full[PGW-1:0];
               state_in  = ST_SPLIT;
            end else if (scan_w_ff == hi_w) begin
               if (lvl_ff == TOP_LVL) begin
                  status_in = STATUS_NO_BLOCK;
                  state_in  = ST_RESP;
               end else begin
                  lvl_in   = lvl_ff + LW'(1);
                  state_in = ST_LEVEL;
               end
            end else begin
               scan_w_in = scan_w_ff + AW'(1);
               state_in  = ST_SCAN_RD;
            end
         end
         ST_SPLIT: begin
            if (lvl_ff > order_ff) begin
               // keep the low half, free the upper half
               lvl_in   = lvl_ff - LW'(1);
               blk_in   = blk_ff << 1;
               state_in = ST_SET_RD;
            end else begin
               result_in = res_full[PAGE_W-1:0];
               state_in  = ST_RESP;
            end
         end
         ST_SET_RD: begin
            state_in = ST_SET_WR;
         end
         ST_SET_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff | bit_mask;
            unique case (op_ff)
               OP_ALLOC: state_in = ST_SPLIT;
               OP_INIT:  state_in = ST_FILL;
               OP_FREE:  state_in = ST_RESP;
               OP_BOOT:  state_in = ST_IDLE;
            endcase
         end
         ST_FREE_RD: begin
            state_in = (lvl_ff == TOP_LVL) ? ST_SET_RD : ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            if (rd_data_ff[bit_idx]) begin
               // buddy is free: drop it and merge one order up
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~bit_mask;
               lvl_in    = lvl_ff + LW'(1);
               blk_in    = blk_ff >> 1;
               state_in  = ST_FREE_RD;
            end else begin
               state_in = ST_SET_RD;
            end
         end
         ST_FILL: begin
            if (fill_ff >= POOL_P) begin
               state_in = ST_RESP;
            end else begin
               lvl_in   = fill_k;
               blk_in   = fill_shift[PGW-1:0];
               fill_in  = fill_ff + (PPW'(1) << fill_k);
               state_in = ST_SET_RD;
            end
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_page_in   = result_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_BOOT;
         clr_ff       <= '0;
         lvl_ff       <= '0;
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         reserved_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         clr_ff       <= clr_in;
         lvl_ff       <= lvl_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) reserved_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff        <= blk_in;
      scan_w_ff     <= scan_w_in;
      fill_ff       <= fill_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem_ff[mem_raddr];
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.result_page = rsp_page_ff;

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while a command is in progress");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_if.ready)
      else $error("ready raised before the bitmap sweep");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= TOP_LVL)
      else $error("order level beyond the pool size");

   a_split_above_request: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |-> (lvl_ff >= order_ff))
      else $error("split went below the requested order");

   a_page_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != STATUS_DONE) |-> (rsp_if.result_page == '0))
      else $error("failed command reports a page");
`endif

endmodule
